### rtl/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg: shared definitions for the positional list
// Operation and status codes, field widths, default depth and cell control.
// ----------------------------------------------------------------------------
package pli_pkg;

	localparam int OP_W     = 2;
	localparam int POS_W    = 5;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int LEN_W    = 5;

	localparam int CAPACITY_DEF = 16;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_ERASE  = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Broadcast to every cell in the cycle an operation commits.
	typedef struct packed {
		logic insert_go;
		logic erase_go;
	} cell_ctl_t;

endpackage

### rtl/pli_req_if.sv
// ----------------------------------------------------------------------------
// pli_req_if: request channel
// Valid/ready channel carrying one list operation per transaction.
// ----------------------------------------------------------------------------
interface pli_req_if;
	logic                              valid;
	logic                              ready;
	logic [pli_pkg::OP_W-1:0]          op;
	logic [pli_pkg::POS_W-1:0]         position;
	logic signed [pli_pkg::VAL_W-1:0]  value;

	modport source (output valid, op, position, value, input ready);
	modport sink (input valid, op, position, value, output ready);
endinterface

### rtl/pli_rsp_if.sv
// ----------------------------------------------------------------------------
// pli_rsp_if: response channel
// Valid/ready channel carrying one operation result per transaction.
// ----------------------------------------------------------------------------
interface pli_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [pli_pkg::STATUS_W-1:0]      status;
	logic [pli_pkg::POS_W-1:0]         done_position;
	logic signed [pli_pkg::VAL_W-1:0]  read_value;
	logic [pli_pkg::LEN_W-1:0]         list_length;

	modport source (output valid, status, done_position, read_value, list_length,
		input ready);
	modport sink (input valid, status, done_position, read_value, list_length,
		output ready);
endinterface

### rtl/pli_cell.sv
// ----------------------------------------------------------------------------
// pli_cell: one list slot
// Holds one entry; loads the new value, takes its left neighbor on an insert
// below it, or its right neighbor on an erase at or below it.
// ----------------------------------------------------------------------------
module pli_cell #(
	parameter int IDX = 0,
	parameter int PW  = 5
) (
	input  logic                             clk,
	input  pli_pkg::cell_ctl_t               ctl,
	input  logic [PW-1:0]                    pos,
	input  logic [PW-1:0]                    cnt,
	input  logic signed [pli_pkg::VAL_W-1:0] ins_value,
	input  logic signed [pli_pkg::VAL_W-1:0] left,
	input  logic signed [pli_pkg::VAL_W-1:0] right,
	output logic signed [pli_pkg::VAL_W-1:0] data
);

	localparam logic [PW-1:0] SELF = PW'(IDX);
	localparam logic [PW:0]   NEXT = (PW+1)'(IDX + 1);

	logic                             load;
	logic                             up;
	logic                             down;
	logic signed [pli_pkg::VAL_W-1:0] data_q;

	assign load = ctl.insert_go && (SELF == pos);
	assign up   = ctl.insert_go && (SELF > pos) && (SELF <= cnt);
	assign down = ctl.erase_go && (SELF >= pos) && (NEXT < {1'b0, cnt});

	// Load the new value or a neighbor, or hold the entry when no operation touches this slot.
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= ins_value;
		end else if (up) begin
			data_q <= left;
		end else if (down) begin
			data_q <= right;
		end
	end

	assign data = data_q;

endmodule

### rtl/positional_list_insert_erase.sv
// ----------------------------------------------------------------------------
// positional_list_insert_erase: ordered list with insert, erase and read
// A row of cells holds the entries; every cell shifts in parallel, so each
// operation commits in the cycle it is accepted.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | op, position, value
//  rsp     | out | status, done_position, read_value, list_length
//
//  One transaction per cycle unless a result stalls: the cell row updates
//  and the result register loads in the same cycle the request is accepted.
//  The result register decouples the sides; req.ready is low only while a
//  result waits and rsp.ready is low.
//  Reset clears the length and the result valid; cell contents are unknown
//  until inserted and are never read before that.
module positional_list_insert_erase #(
	parameter int CAPACITY = pli_pkg::CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	pli_req_if.sink   req,
	pli_rsp_if.source rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > pli_pkg::POS_W) ? CW : pli_pkg::POS_W;

	logic [CW-1:0]                    count_q;
	logic [CW-1:0]                    count_d;
	logic                             rsp_valid_q;
	logic [pli_pkg::STATUS_W-1:0]     status_q;
	logic [pli_pkg::POS_W-1:0]        done_pos_q;
	logic signed [pli_pkg::VAL_W-1:0] read_value_q;
	logic [pli_pkg::LEN_W-1:0]        length_q;

	logic                             req_fire;
	logic [PW-1:0]                    pos_x;
	logic [PW-1:0]                    cnt_x;
	logic                             full;
	logic                             in_range;
	logic                             ins_ok;
	logic                             era_ok;
	logic                             rd_ok;
	pli_pkg::status_t                 status_d;
	logic signed [pli_pkg::VAL_W-1:0] rd_data;
	pli_pkg::cell_ctl_t               ctl;
	logic signed [pli_pkg::VAL_W-1:0] cell_data [CAPACITY];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign req_fire  = req.valid && req.ready;

	assign pos_x    = PW'(req.position);
	assign cnt_x    = PW'(count_q);
	assign full     = (count_q == CW'(CAPACITY));
	assign in_range = (pos_x < cnt_x);

	assign ins_ok = (req.op == pli_pkg::OP_INSERT) && (pos_x <= cnt_x) && !full;
	assign era_ok = (req.op == pli_pkg::OP_ERASE) && in_range;
	assign rd_ok  = (req.op == pli_pkg::OP_READ) && in_range;

	assign ctl.insert_go = req_fire && ins_ok;
	assign ctl.erase_go  = req_fire && era_ok;

	always_comb begin
		status_d = pli_pkg::ST_RANGE;
		if (ins_ok || era_ok || rd_ok) begin
			status_d = pli_pkg::ST_DONE;
		end else if ((req.op == pli_pkg::OP_INSERT) && (pos_x <= cnt_x)) begin
			status_d = pli_pkg::ST_FULL;
		end
	end

	always_comb begin
		count_d = count_q;
		if (ins_ok) begin
			count_d = count_q + CW'(1);
		end else if (era_ok) begin
			count_d = count_q - CW'(1);
		end
	end

	// Pick the addressed cell: only one index can match.
	always_comb begin
		rd_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (PW'(i) == pos_x) begin
				rd_data = rd_data | cell_data[i];
			end
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		pli_cell #(
			.IDX (g),
			.PW  (PW)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.pos       (pos_x),
			.cnt       (cnt_x),
			.ins_value (req.value),
			.left      ((g == 0) ? req.value : cell_data[(g == 0) ? 0 : g - 1]),
			.right     ((g == CAPACITY - 1) ? '0 :
				cell_data[(g == CAPACITY - 1) ? g : g + 1]),
			.data      (cell_data[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (req_fire) begin
				rsp_valid_q <= 1'b1;
				count_q     <= count_d;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			status_q     <= status_d;
			done_pos_q   <= (status_d == pli_pkg::ST_DONE) ? req.position : '0;
			read_value_q <= rd_ok ? rd_data : '0;
			length_q     <= pli_pkg::LEN_W'(count_d);
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.done_position = done_pos_q;
	assign rsp.read_value    = read_value_q;
	assign rsp.list_length   = length_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("list length above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.insert_go |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the list");

	a_length_reported: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> rsp.list_length == pli_pkg::LEN_W'(count_q))
		else $error("reported length differs from list length");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |-> !req.ready)
		else $error("request taken while result stalled");
`endif

endmodule
